// ----- rtl/pdtm_pkg.sv -----
package pdtm_pkg;

    // Field widths
    localparam int ANGLE_W = 17;
    localparam int DT_W    = 16;
    localparam int ERR_W   = 18;
    localparam int GAIN_W  = 32;
    localparam int PULSE_W = 11;
    localparam int INTEG_W = 48;
    localparam int DK_W    = 29;               // (error delta) * 1000
    localparam int PROD_W  = GAIN_W + DK_W;    // shared multiplier product
    localparam int ACC_W   = 64;

    // Divider: one quotient bit per cycle over the product magnitude
    localparam int DIV_W   = PROD_W;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

    // Constants of the control law
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;
    localparam logic signed [PROD_W:0] INTEG_HI = 62'sh7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W:0] INTEG_LO = -INTEG_HI - 62'sd1;

    // Register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 32'd1499464;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 32'd839;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 32'd650117;
    localparam logic [PULSE_W-1:0] THROTTLE_RST   = 11'd1300;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_BASE_THROTTLE = 3'd3,
        REG_TARGET_ANGLE  = 3'd4
    } t_reg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_INTEG,
        ST_MUL_D,
        ST_DIV_INIT,
        ST_DIV,
        ST_ADD_D,
        ST_CLAMP,
        ST_CORR,
        ST_OUT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_P,
        OP_MUL_I,
        OP_INTEG,
        OP_MUL_D,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ADD_D,
        OP_CLAMP,
        OP_CORR,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   last_step;   // final divider iteration
    } t_cmd;

    typedef struct packed {
        logic out_free;      // output register empty or being drained
    } t_status;

    // Clamp a mixed pulse width to the legal motor range
    function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [12:0] v);
        logic [PULSE_W-1:0] res;
        if (v < 13'sd1000) begin
            res = PULSE_MIN;
        end else if (v > 13'sd2000) begin
            res = PULSE_MAX;
        end else begin
            res = v[PULSE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/pid_differential_thrust_mixer.sv -----
// Tilt PID controller with differential thrust mixing.
//
// Input stream (s_axis): one sample per transfer, the measured tilt angle
// and the milliseconds since the previous sample. Output stream (m_axis):
// one result per sample, left and right motor pulse widths, the clamped
// correction and the angle error; tuser flags saturation of the PID sum or
// the integral. Gains, throttle and target are written on the cfg channel;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Writing the integral gain clears the integral.
//
// A sample passes through the states MUL_P, MUL_I, INTEG, MUL_D, DIV_INIT,
// DIV, ADD_D, CLAMP, CORR and OUT around one shared 32x29 multiplier; the
// derivative division is a restoring divider producing one quotient bit per
// cycle over 61 bits. The next sample is taken only after the previous result
// has entered the output register; that step waits while the register is full.
//
// Reset restores the default gains and clears the integral and the stored
// previous error; no channel is ready while reset is held. A result waits in
// the output register while the receiver stalls; the next sample is accepted
// and computed meanwhile, and its result waits until the register drains.
module pid_differential_thrust_mixer
    import pdtm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // [16:0] measured_angle, [32:17] elapsed_ms
    input  logic [39:0]           s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [10:0] left_pulse, [21:11] right_pulse, [32:22] correction,
    // [50:33] angle_error
    output logic [55:0]           m_axis_tdata,
    // [0] clamped
    output logic                  m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [GAIN_W-1:0]     i_cfg_data
);

    t_cmd                      cmd;
    t_status                   status;
    logic [PULSE_W-1:0]        left, right;
    logic signed [PULSE_W-1:0] corr;
    logic signed [ERR_W-1:0]   err;

    pdtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    pdtm_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_angle     (s_axis_tdata[16:0]),
        .i_elapsed   (s_axis_tdata[32:17]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (left),
        .o_right     (right),
        .o_corr      (corr),
        .o_err       (err),
        .o_sat       (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b0, err, corr, right, left};

endmodule

// ----- rtl/pdtm_ctrl.sv -----
module pdtm_ctrl
    import pdtm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sequencing of one sample through the shared datapath
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_in_ready       = 1'b0;
        o_cmd.op         = OP_NONE;
        o_cmd.last_step  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                o_cmd.op = OP_MUL_P;
                n_state  = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.op = OP_MUL_I;
                n_state  = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.op = OP_MUL_D;
                n_state  = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    o_cmd.last_step = 1'b1;
                    n_state         = ST_ADD_D;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ADD_D: begin
                o_cmd.op = OP_ADD_D;
                n_state  = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = ST_CORR;
            end
            ST_CORR: begin
                o_cmd.op = OP_CORR;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A transfer in starts the multiply sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MUL_P))
        else $error("accepted sample did not start the sequence");

    // The divider runs exactly its fixed number of iterations
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == DIV_LAST) |=> (r_state == ST_ADD_D))
        else $error("divider did not finish on its last iteration");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider count out of range");

endmodule

// ----- rtl/pdtm_datapath.sv -----
module pdtm_datapath
    import pdtm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [DT_W-1:0]           i_elapsed,
    input  logic                      i_cfg_valid,
    input  logic [2:0]                i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    output logic                      o_cfg_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PULSE_W-1:0]        o_left,
    output logic [PULSE_W-1:0]        o_right,
    output logic signed [PULSE_W-1:0] o_corr,
    output logic signed [ERR_W-1:0]   o_err,
    output logic                      o_sat
);

    localparam int ACC_FRAC = 8 + GAIN_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_LIM    = 64'sd1000 <<< ACC_FRAC;
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (64'sd1 <<< ACC_FRAC) - 64'sd1;

    // Configuration registers
    logic signed [GAIN_W-1:0]  r_kp, r_ki, r_kd;
    logic [PULSE_W-1:0]        r_base;
    logic signed [ANGLE_W-1:0] r_target;

    // Working registers
    logic signed [ERR_W-1:0]   r_err, r_last;
    logic [DT_W-1:0]           r_dt;
    logic signed [DK_W-1:0]    r_dk;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_sat;
    logic                      r_neg;
    logic [DIV_W-1:0]          r_quo;
    logic [DT_W-1:0]           r_rem;
    logic signed [PULSE_W-1:0] r_corr;

    // Output register
    logic                      r_out_valid;
    logic [PULSE_W-1:0]        r_out_left, r_out_right;
    logic signed [PULSE_W-1:0] r_out_corr;
    logic signed [ERR_W-1:0]   r_out_err;
    logic                      r_out_sat;

    logic                      cfg_wr;
    logic signed [ERR_W:0]     derr;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [DK_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_res;
    logic signed [PROD_W:0]    integ_sum;
    logic [DT_W:0]             div_shift;
    logic [DT_W+1:0]           div_diff;
    logic signed [PROD_W:0]    d_mag, d_val;
    logic signed [ACC_W-1:0]   corr_biased, corr_shift;
    logic signed [12:0]        base_s, corr_s;

    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = i_rst_n;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MUL_I: begin
                mul_a = r_ki;
                mul_b = DK_W'(r_err);
            end
            OP_MUL_D: begin
                mul_a = r_kd;
                mul_b = r_dk;
            end
            default: begin
                mul_a = r_kp;
                mul_b = DK_W'(r_err);
            end
        endcase
    end
    assign mul_res = mul_a * mul_b;

    // Error delta, integral update, divider step and output mix
    assign derr        = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_last);
    assign integ_sum   = (PROD_W+1)'(r_integ) + (PROD_W+1)'(r_prod);
    assign div_shift   = {r_rem, r_quo[DIV_W-1]};
    assign div_diff    = {1'b0, div_shift} - {2'b00, r_dt};
    assign d_mag       = signed'({1'b0, r_quo});
    assign d_val       = r_neg ? -d_mag : d_mag;
    assign corr_biased = r_acc + (r_acc[ACC_W-1] ? TRUNC_BIAS : '0);
    assign corr_shift  = corr_biased >>> ACC_FRAC;
    assign base_s      = signed'({2'b00, r_base});
    assign corr_s      = 13'(r_corr);

    // Configuration registers; an integral gain write clears the integral
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= PROP_GAIN_RST;
            r_ki     <= INTEG_GAIN_RST;
            r_kd     <= DERIV_GAIN_RST;
            r_base   <= THROTTLE_RST;
            r_target <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_PROP_GAIN:     r_kp     <= i_cfg_data;
                REG_INTEG_GAIN:    r_ki     <= i_cfg_data;
                REG_DERIV_GAIN:    r_kd     <= i_cfg_data;
                REG_BASE_THROTTLE: r_base   <= i_cfg_data[PULSE_W-1:0];
                REG_TARGET_ANGLE:  r_target <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Loop state: integral and previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            if (cfg_wr && i_cfg_index == REG_INTEG_GAIN) begin
                r_integ <= '0;
            end else if (i_cmd.op == OP_INTEG) begin
                if (integ_sum > INTEG_HI) begin
                    r_integ <= INTEG_HI[INTEG_W-1:0];
                end else if (integ_sum < INTEG_LO) begin
                    r_integ <= INTEG_LO[INTEG_W-1:0];
                end else begin
                    r_integ <= integ_sum[INTEG_W-1:0];
                end
            end
            if (i_cmd.op == OP_MUL_D) begin
                r_last <= r_err;
            end
        end
    end

    // Per-sample arithmetic
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_err <= ERR_W'(i_angle) - ERR_W'(r_target);
                r_dt  <= (i_elapsed == '0) ? DT_W'(1) : i_elapsed;
                r_sat <= 1'b0;
            end
            OP_MUL_P: begin
                r_prod <= mul_res;
                r_dk   <= DK_W'(derr) * 29'sd1000;
            end
            OP_MUL_I: begin
                r_acc  <= ACC_W'(r_prod);
                r_prod <= mul_res;
            end
            OP_INTEG: begin
                if (integ_sum > INTEG_HI || integ_sum < INTEG_LO) begin
                    r_sat <= 1'b1;
                end
            end
            OP_MUL_D: begin
                r_acc  <= r_acc + ACC_W'(r_integ);
                r_prod <= mul_res;
            end
            OP_DIV_INIT: begin
                r_neg <= r_prod[PROD_W-1];
                r_quo <= r_prod[PROD_W-1] ? DIV_W'(-r_prod) : DIV_W'(r_prod);
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                if (!div_diff[DT_W+1]) begin
                    r_rem <= div_diff[DT_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= div_shift[DT_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
            end
            OP_ADD_D: begin
                r_acc <= r_acc + ACC_W'(d_val);
            end
            OP_CLAMP: begin
                if (r_acc > ACC_LIM) begin
                    r_acc <= ACC_LIM;
                    r_sat <= 1'b1;
                end else if (r_acc < -ACC_LIM) begin
                    r_acc <= -ACC_LIM;
                    r_sat <= 1'b1;
                end
            end
            OP_CORR: begin
                r_corr <= corr_shift[PULSE_W-1:0];
            end
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload with motor mix
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out_left  <= clamp_pulse(base_s - corr_s);
            r_out_right <= clamp_pulse(base_s + corr_s);
            r_out_corr  <= r_corr;
            r_out_err   <= r_err;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_left;
    assign o_right     = r_out_right;
    assign o_corr      = r_out_corr;
    assign o_err       = r_out_err;
    assign o_sat       = r_out_sat;

    // Divider remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_STEP) |-> (r_rem < r_dt))
        else $error("divider remainder not below divisor");

    // Correction is within the clamp when it is mixed
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> (r_corr <= 11'sd1000 && r_corr >= -11'sd1000))
        else $error("correction outside clamp");

    // Integral gain write clears the integral
    a_integ_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_cfg_index == REG_INTEG_GAIN) |=> (r_integ == '0))
        else $error("integral not cleared by gain write");

endmodule
